[src/erfs_pkg.sv]
`timescale 1ns / 1ps

package erfs_pkg;

   // Field widths fixed by the interface
   localparam int TIME_W   = 48;
   localparam int COUNT_W  = 16;
   localparam int STAMP_W  = 32;
   localparam int ROOM_W   = 4;
   localparam int CFG_W    = 5;

   // Built room capacity and register reset value
   localparam int                MAX_ROOMS_DEFAULT = 16;
   localparam logic [CFG_W-1:0]  ROOM_COUNT_RESET  = 5'd16;

   // Saturation limits
   localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // One room entry as held in memory
   typedef struct packed {
      logic [COUNT_W-1:0] uses;
      logic [TIME_W-1:0]  free_at;
   } entry_type;

   // One scheduling result from the core to the output register
   typedef struct packed {
      logic [COUNT_W-1:0] busiest_count;
      logic [ROOM_W-1:0]  busiest_room;
      logic [TIME_W-1:0]  finish_time;
      logic [ROOM_W-1:0]  assigned_room;
   } result_type;

endpackage

[src/erfs_room_mem.sv]
`timescale 1ns / 1ps

module erfs_room_mem
   import erfs_pkg::*;
#(
   parameter int MAX_ROOMS = MAX_ROOMS_DEFAULT,
   localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data
);

   entry_type              mem [MAX_ROOMS];
   logic [MAX_ROOMS-1:0]   valid_ff;
   entry_type              rd_data_ff;
   logic                   rd_hit_ff;

   // Entry storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Written flags; an unwritten room reads as free at zero with no uses
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

[src/erfs_sched_core.sv]
`timescale 1ns / 1ps

module erfs_sched_core
   import erfs_pkg::*;
#(
   parameter int MAX_ROOMS = MAX_ROOMS_DEFAULT,
   localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1,
   localparam int CNT_W = $clog2(MAX_ROOMS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  logic [STAMP_W-1:0] start_time,
   input  logic [STAMP_W-1:0] end_time,
   input  logic [CNT_W-1:0]   room_limit,
   input  logic               out_free,
   output logic               res_valid,
   output result_type         res,
   output logic               rd_en,
   output logic [IDX_W-1:0]   rd_addr,
   input  entry_type          rd_data,
   output logic               wr_en,
   output logic [IDX_W-1:0]   wr_addr,
   output entry_type          wr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [STAMP_W-1:0] start_ff, start_in;
   logic [STAMP_W-1:0] dur_ff, dur_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   found_room_ff, found_room_in;
   logic [COUNT_W-1:0] found_uses_ff, found_uses_in;
   logic [IDX_W-1:0]   early_room_ff, early_room_in;
   logic [TIME_W-1:0]  early_free_ff, early_free_in;
   logic [COUNT_W-1:0] early_uses_ff, early_uses_in;
   logic [IDX_W-1:0]   best_room_ff, best_room_in;
   logic [COUNT_W-1:0] best_count_ff, best_count_in;

   logic               accept;
   logic               fire;
   logic [IDX_W-1:0]   chosen;
   logic [TIME_W-1:0]  base_time;
   logic [COUNT_W-1:0] uses_sel;
   logic [TIME_W:0]    finish_sum;
   logic [TIME_W-1:0]  finish;
   logic [COUNT_W-1:0] new_uses;
   logic               take_best;

   assign job_ready = (state_ff == ST_IDLE);
   assign accept    = job_valid && job_ready;
   assign fire      = (state_ff == ST_DECIDE) && out_free;

   // Decision: first free room, else the earliest-freeing one
   assign chosen     = found_ff ? found_room_ff : early_room_ff;
   assign base_time  = found_ff ? {{(TIME_W-STAMP_W){1'b0}}, start_ff} : early_free_ff;
   assign uses_sel   = found_ff ? found_uses_ff : early_uses_ff;
   assign finish_sum = {1'b0, base_time} + {{(TIME_W+1-STAMP_W){1'b0}}, dur_ff};
   assign finish     = finish_sum[TIME_W] ? TIME_MAX : finish_sum[TIME_W-1:0];
   assign new_uses   = (uses_sel == COUNT_MAX) ? uses_sel : uses_sel + 1'b1;
   assign take_best  = (new_uses > best_count_ff) ||
                       ((new_uses == best_count_ff) && (chosen < best_room_ff));

   // Write-back and result
   assign wr_en             = fire;
   assign wr_addr           = chosen;
   assign wr_data.free_at   = finish;
   assign wr_data.uses      = new_uses;
   assign res_valid         = fire;
   assign res.assigned_room = ROOM_W'(chosen);
   assign res.finish_time   = finish;
   assign res.busiest_room  = ROOM_W'(take_best ? chosen : best_room_ff);
   assign res.busiest_count = take_best ? new_uses : best_count_ff;

   // Sequencer: one read per room, compare as the data returns
   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      dur_in        = dur_ff;
      limit_in      = limit_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      found_room_in = found_room_ff;
      found_uses_in = found_uses_ff;
      early_room_in = early_room_ff;
      early_free_in = early_free_ff;
      early_uses_in = early_uses_ff;
      best_room_in  = best_room_ff;
      best_count_in = best_count_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               start_in    = start_time;
               dur_in      = (end_time > start_time) ? end_time - start_time : '0;
               limit_in    = room_limit;
               rd_en       = 1'b1;
               rd_addr     = '0;
               issue_in    = CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = '0;
               found_in    = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_in = 1'b0;
            if (issue_ff < limit_ff) begin
               rd_en       = 1'b1;
               rd_addr     = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               if (!found_ff &&
                   (rd_data.free_at <= {{(TIME_W-STAMP_W){1'b0}}, start_ff})) begin
                  found_in      = 1'b1;
                  found_room_in = pend_idx_ff;
                  found_uses_in = rd_data.uses;
               end
               if ((pend_idx_ff == '0) || (rd_data.free_at < early_free_ff)) begin
                  early_room_in = pend_idx_ff;
                  early_free_in = rd_data.free_at;
                  early_uses_in = rd_data.uses;
               end
               if (CNT_W'(pend_idx_ff) == limit_ff - 1'b1) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (fire) begin
               if (take_best) begin
                  best_room_in  = chosen;
                  best_count_in = new_uses;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         best_room_ff  <= '0;
         best_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         best_room_ff  <= best_room_in;
         best_count_ff <= best_count_in;
      end
   end

   // Job payload and scan accumulators
   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      dur_ff        <= dur_in;
      limit_ff      <= limit_in;
      issue_ff      <= issue_in;
      pend_idx_ff   <= pend_idx_in;
      found_room_ff <= found_room_in;
      found_uses_ff <= found_uses_in;
      early_room_ff <= early_room_in;
      early_free_ff <= early_free_in;
      early_uses_ff <= early_uses_in;
   end

   // A room entry is written back only when the output slot can take the result
   a_write_needs_slot: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> out_free && (state_ff == ST_DECIDE))
      else $error("room write-back without a free output slot");

   // Returning read data always belongs to a room inside the job's limit
   a_pend_in_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CNT_W'(pend_idx_ff) < limit_ff))
      else $error("scan read beyond the room limit");

   // No new job is taken while a scan or write-back is outstanding
   a_one_job: assert property (@(posedge clock) disable iff (reset)
      fire |=> job_ready && !pend_ff)
      else $error("sequencer not idle after write-back");

   // The busiest count never falls
   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> best_count_ff >= $past(best_count_ff))
      else $error("busiest count decreased");

endmodule

[src/earliest_free_room_scheduler.sv]
`timescale 1ns / 1ps

// Earliest-free room scheduler. Each job transfer (start, end) is placed in
// the lowest-numbered room free by its start time, or failing that in the
// room that frees earliest, where it starts when that room frees. Room free
// times and use counts sit in one memory with a registered read; a job walks
// that memory one room a cycle. The next transfer is taken only once the job
// is through its steps: one read per room, the return of the last read, and
// the decision and write-back, which wait until the output register can take
// the result. The result waits in an output register while the next job is
// scanned. room_count may only be written while no job is in flight; zero is
// taken as one room and values above MAX_ROOMS as MAX_ROOMS.
module earliest_free_room_scheduler
   import erfs_pkg::*;
#(
   parameter int MAX_ROOMS = MAX_ROOMS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // [31:0] start_time, [63:32] end_time
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,
   // [3:0] assigned_room, [51:4] finish_time, [55:52] busiest_room,
   // [71:56] busiest_count
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,
   input  logic              csr_wen,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
   localparam int CNT_W = $clog2(MAX_ROOMS + 1);

   logic [CFG_W-1:0] room_count_ff, room_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0] room_limit;
   logic             out_free;
   logic             res_valid;
   result_type       res;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // Room count register and its clamp to the built capacity
   assign room_count_in = csr_wen ? csr_wdata : room_count_ff;

   always_comb begin
      if (room_count_ff == '0) begin
         room_limit = CNT_W'(1);
      end else if (32'(room_count_ff) > MAX_ROOMS) begin
         room_limit = CNT_W'(MAX_ROOMS);
      end else begin
         room_limit = CNT_W'(room_count_ff);
      end
   end

   // Output register
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = res_valid ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         room_count_ff <= ROOM_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         room_count_ff <= room_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   erfs_sched_core #(
      .MAX_ROOMS (MAX_ROOMS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (req_tvalid),
      .job_ready  (req_tready),
      .start_time (req_tdata[31:0]),
      .end_time   (req_tdata[63:32]),
      .room_limit (room_limit),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   erfs_room_mem #(
      .MAX_ROOMS (MAX_ROOMS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule
